### design/voice_frame_deframer_top_assert.svh
// Assertion macros for the voice frame deframer checker
`ifndef VOICE_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define VOICE_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define VFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/vfd_pkg.sv
// Types and constants shared by the voice frame deframer
package vfd_pkg;

  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned STORE_BYTES = 2 * FRAME_BYTES;
  localparam int unsigned CHECK_POS   = 15;
  localparam int unsigned RES_DEPTH   = 4;
  localparam int unsigned RES_PTR_W   = 2;
  localparam int unsigned RES_LVL_W   = 3;
  localparam int unsigned OUT_TDATA_W = 136;

  localparam logic [7:0] PAT_FILL = 8'h55;
  localparam logic [7:0] PAT_SYNC = 8'hC8;
  localparam logic [7:0] PAT_TAIL = 8'h7A;
  localparam logic [6:0] SEQ_END_FLAG = 7'h40;

  localparam logic [3:0] CNT_MARKER = 4'd0;
  localparam logic [3:0] CNT_END_SHORT = 4'd3;
  localparam logic [3:0] CNT_END_FULL = 4'd6;
  localparam logic [3:0] CNT_VOICE = 4'd12;
  localparam logic [3:0] CNT_LAST = 4'd15;

  typedef enum logic [1:0] {
    MODE_DATA      = 2'd0,
    MODE_START     = 2'd1,
    MODE_FORCE_END = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VOICE  = 2'd0,
    KIND_MARKER = 2'd1,
    KIND_LAST   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  seq;
    logic [63:0] lo;
    logic [55:0] hi;
    logic [3:0]  cnt;
    logic        last;
  } vfd_result_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } vfd_cell_ctl_t;

endpackage

### design/voice_frame_deframer_top.sv
// Voice frame deframer: byte cell row, frame builder and result queue
// The results of an accepted item are written into the result queue and registered there.
// Throughput: one item per cycle while the 4-entry queue has two free entries;
// a run of items with two results each is then held back by the output.
// Synchronous active-low reset clears the cells, fill position, sequence,
// enable register and queue.
module voice_frame_deframer_top #(
  parameter int unsigned FRAMES_PER_SUPERFRAME = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // forward_enable
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,      // data_byte[7:0]
  input  logic [1:0]   in_tuser,      // mode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,     // frame_seq[6:0], bytes_low[70:7],
                                      // bytes_high[126:71], byte_count[130:127], zero pad
  output logic [1:0]   out_tuser,     // kind[1:0]
  output logic         out_tlast      // last
);
  import vfd_pkg::*;

  localparam logic [4:0] WRAP_AT = 5'(FRAMES_PER_SUPERFRAME);

  logic [7:0]    store [STORE_BYTES];
  vfd_cell_ctl_t cell_ctl [STORE_BYTES];
  logic [7:0]    cell_nbr [STORE_BYTES];

  logic [4:0]  fill_r, fill_nxt;
  logic [4:0]  seq_r, seq_nxt;
  logic        en_r, en_nxt;
  logic        in_acc, space_ok, is_full, is_check, match, wrap;
  logic [4:0]  seq_inc;
  mode_t       mode;
  logic [1:0]  push_n;
  vfd_result_t res_a, res_b, out_res;
  vfd_result_t r_voice, r_last, r_end3, r_end6, r_marker;

  assign in_tready = space_ok;
  assign in_acc    = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tuser);
  assign is_full   = (fill_r == 5'(STORE_BYTES - 1));
  assign is_check  = (fill_r == 5'(CHECK_POS - 1));
  assign seq_inc   = seq_r + 5'd1;
  assign wrap      = (seq_inc >= WRAP_AT);
  assign match     = (store[9] == PAT_FILL) && (store[10] == PAT_FILL) &&
                     (store[11] == PAT_FILL) && (store[12] == PAT_FILL) &&
                     (store[13] == PAT_SYNC) && (in_tdata == PAT_TAIL);

  for (genvar i = 0; i < STORE_BYTES; i++) begin : g_cell
    if (i < FRAME_BYTES) begin : g_lo
      if (i + FRAME_BYTES == STORE_BYTES - 1) begin : g_edge
        assign cell_nbr[i] = in_tdata;
      end else begin : g_mid
        assign cell_nbr[i] = store[i + FRAME_BYTES];
      end
      assign cell_ctl[i].shift = in_acc && (mode == MODE_DATA) && is_full;
    end else begin : g_hi
      assign cell_nbr[i]       = store[i];
      assign cell_ctl[i].shift = 1'b0;
    end
    assign cell_ctl[i].wr = in_acc && (mode == MODE_DATA) && (fill_r == 5'(i));

    vfd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl[i]),
      .data_in (in_tdata),
      .nbr_in  (cell_nbr[i]),
      .byte_q  (store[i])
    );
  end

  always_comb begin
    r_voice      = '0;
    r_voice.kind = KIND_VOICE;
    r_voice.seq  = {2'b00, seq_r};
    r_voice.cnt  = CNT_VOICE;
    for (int k = 0; k < 8; k++) begin
      r_voice.lo[8*k +: 8] = store[k];
    end
    for (int k = 0; k < 4; k++) begin
      r_voice.hi[8*k +: 8] = store[8 + k];
    end

    r_last      = r_voice;
    r_last.kind = KIND_LAST;
    r_last.cnt  = CNT_LAST;
    for (int k = 4; k < 6; k++) begin
      r_last.hi[8*k +: 8] = store[8 + k];
    end
    r_last.hi[55:48] = in_tdata;

    r_end3      = '0;
    r_end3.kind = KIND_END;
    r_end3.seq  = SEQ_END_FLAG | {2'b00, seq_inc};
    r_end3.cnt  = CNT_END_SHORT;
    r_end3.lo   = {40'd0, PAT_TAIL, PAT_SYNC, PAT_FILL};

    r_end6      = '0;
    r_end6.kind = KIND_END;
    r_end6.seq  = SEQ_END_FLAG | {2'b00, seq_r};
    r_end6.cnt  = CNT_END_FULL;
    r_end6.lo   = {16'd0, PAT_TAIL, PAT_SYNC, PAT_FILL, PAT_FILL, PAT_FILL, PAT_FILL};

    r_marker      = '0;
    r_marker.kind = KIND_MARKER;
    r_marker.cnt  = CNT_MARKER;
  end

  always_comb begin
    push_n = 2'd0;
    res_a  = r_voice;
    res_b  = r_end3;
    if (in_acc) begin
      case (mode)
        MODE_DATA: begin
          if (is_full) begin
            if (wrap) begin
              res_a  = r_marker;
              res_b  = r_voice;
              push_n = en_r ? 2'd2 : 2'd1;
            end else if (en_r) begin
              res_a  = r_voice;
              push_n = 2'd1;
            end
          end else if (is_check && match && en_r) begin
            res_a  = r_last;
            res_b  = r_end3;
            push_n = 2'd2;
          end
        end
        MODE_FORCE_END: begin
          if (en_r) begin
            res_a  = r_end6;
            push_n = 2'd1;
          end
        end
        default: ;
      endcase
    end
    res_a.last = (push_n == 2'd1);
    res_b.last = 1'b1;
  end

  always_comb begin
    fill_nxt = fill_r;
    seq_nxt  = seq_r;
    en_nxt   = cfg_wr_en ? cfg_wr_data : en_r;
    if (in_acc) begin
      case (mode)
        MODE_START: begin
          seq_nxt = '0;
        end
        MODE_DATA: begin
          if (is_full) begin
            fill_nxt = 5'(FRAME_BYTES);
            seq_nxt  = wrap ? 5'd0 : seq_inc;
          end else begin
            fill_nxt = fill_r + 5'd1;
            if (is_check && match) begin
              seq_nxt = seq_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seq_r  <= '0;
      en_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      seq_r  <= seq_nxt;
      en_r   <= en_nxt;
    end
  end

  vfd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.cnt, out_res.hi, out_res.lo, out_res.seq};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

### design/vfd_cell.sv
// One byte cell of the deframer store
module vfd_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vfd_pkg::vfd_cell_ctl_t ctl,
  input  logic [7:0]             data_in,
  input  logic [7:0]             nbr_in,
  output logic [7:0]             byte_q
);
  import vfd_pkg::*;

  logic [7:0] byte_r, byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = nbr_in;
    end else if (ctl.wr) begin
      byte_nxt = data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

### design/vfd_result_fifo.sv
// Result queue between the deframer core and the output channel
module vfd_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  vfd_pkg::vfd_result_t push_a,
  input  vfd_pkg::vfd_result_t push_b,
  output logic                 space_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vfd_pkg::vfd_result_t out_res
);
  import vfd_pkg::*;

  vfd_result_t           mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RES_LVL_W-1:0]  level_r, level_nxt;
  logic [RES_PTR_W-1:0]  wr_ptr_b;
  logic                  pop;

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rd_ptr_r];
  assign space_ok  = (level_r <= RES_LVL_W'(RES_DEPTH - 2));
  assign wr_ptr_b  = wr_ptr_r + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    level_nxt  = level_r + RES_LVL_W'(push_n) - RES_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

### design/vfd_checker.sv
// Port-level checker for the voice frame deframer, bound to the top level
`include "voice_frame_deframer_top_assert.svh"

module vfd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import vfd_pkg::*;

  logic [6:0]  seq;
  logic [55:0] hi;
  logic [3:0]  cnt;

  assign seq = out_tdata[6:0];
  assign hi  = out_tdata[126:71];
  assign cnt = out_tdata[130:127];

  `VFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled result changed")

  `VFD_ASSERT_IMPL(a_count_kind, clk, rst_n, out_tvalid,
    ((out_tuser == KIND_VOICE) && (cnt == CNT_VOICE)) ||
    ((out_tuser == KIND_MARKER) && (cnt == CNT_MARKER) && (seq == 7'd0)) ||
    ((out_tuser == KIND_LAST) && (cnt == CNT_LAST)) ||
    ((out_tuser == KIND_END) && seq[6] &&
     ((cnt == CNT_END_SHORT) || (cnt == CNT_END_FULL))),
    "byte count does not fit kind")

  `VFD_ASSERT_IMPL(a_tlast_kind, clk, rst_n,
    out_tvalid && ((out_tuser == KIND_LAST) || (out_tuser == KIND_END)),
    out_tlast == (out_tuser == KIND_END), "wrong tlast on last or end frame")

  `VFD_ASSERT_NEXT(a_end_follows_last, clk, rst_n,
    out_tvalid && out_tready && (out_tuser == KIND_LAST),
    out_tvalid && (out_tuser == KIND_END), "last frame not followed by end frame")

  `VFD_ASSERT_IMPL(a_voice_tail_zero, clk, rst_n,
    out_tvalid && (out_tuser == KIND_VOICE), hi[55:32] == 24'd0,
    "voice frame bytes beyond count not zero")

endmodule

bind voice_frame_deframer_top vfd_checker u_vfd_checker (.*);

### tb/voice_frame_deframer_top_tb.sv
// Self-checking testbench for the voice frame deframer: directed and random byte streams
module voice_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfd_pkg::*;

  localparam int unsigned FPS           = 21;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned PHASES        = 6;
  localparam logic [5:0]  PHASE_EN      = 6'b101011;
  localparam logic [5:0]  PHASE_GAPS    = 6'b101101;
  localparam logic [47:0] END_PATTERN   =
    {PAT_TAIL, PAT_SYNC, PAT_FILL, PAT_FILL, PAT_FILL, PAT_FILL};
  localparam logic [71:0] LEAD_BYTES    = 72'h7A_C8_55_AA_7F_80_01_FF_00;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_HALF,
    RX_PERIODIC
  } rx_style_t;

  class frame_scoreboard;
    logic [7:0]  store [STORE_BYTES];
    int unsigned fill;
    logic [4:0]  seq_ctr;
    bit          in_tx;
    bit          fwd_en;
    int unsigned frames_per_sf;
    vfd_result_t due_frames [$];
    int unsigned errors;

    function new(int unsigned fps);
      foreach (store[i]) store[i] = 8'h00;
      frames_per_sf = fps;
      fill = 0;
      seq_ctr = '0;
      in_tx = 1'b0;
      fwd_en = 1'b0;
      errors = 0;
    endfunction

    function vfd_result_t frame_of(kind_t k, logic [6:0] s, logic [119:0] bytes,
                                   logic [3:0] n);
      vfd_result_t r;
      r.kind = k;
      r.seq = s;
      r.lo = '0;
      r.hi = '0;
      r.cnt = n;
      r.last = 1'b0;
      for (int i = 0; i < 15; i++) begin
        if (i < n) begin
          if (i < 8) r.lo[8*i +: 8] = bytes[8*i +: 8];
          else r.hi[8*(i-8) +: 8] = bytes[8*i +: 8];
        end
      end
      return r;
    endfunction

    function void take_item(logic [1:0] mode, logic [7:0] b);
      vfd_result_t  fresh [$];
      logic [119:0] fb;
      logic [6:0]   s;
      int unsigned  pos;
      bit           hit;
      fb = '0;
      case (mode)
        MODE_START: begin
          seq_ctr = '0;
          in_tx = 1'b1;
        end
        MODE_FORCE_END: begin
          if (fwd_en)
            fresh.push_back(frame_of(KIND_END, {2'b00, seq_ctr} | SEQ_END_FLAG,
                                     120'(END_PATTERN), CNT_END_FULL));
          in_tx = 1'b0;
        end
        MODE_DATA: begin
          pos = (fill >= STORE_BYTES) ? STORE_BYTES - 1 : fill;
          store[pos] = b;
          pos++;
          if (pos == STORE_BYTES) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
              fb[8*i +: 8] = store[i];
              store[i] = store[i + FRAME_BYTES];
            end
            s = {2'b00, seq_ctr};
            pos = FRAME_BYTES;
            seq_ctr = seq_ctr + 5'd1;
            if (seq_ctr >= frames_per_sf) begin
              seq_ctr = '0;
              fresh.push_back(frame_of(KIND_MARKER, 7'd0, '0, CNT_MARKER));
            end
            if (fwd_en) fresh.push_back(frame_of(KIND_VOICE, s, fb, CNT_VOICE));
          end else if (pos == CHECK_POS) begin
            hit = 1'b1;
            for (int i = 0; i < 6; i++)
              if (store[CHECK_POS - 6 + i] != END_PATTERN[8*i +: 8]) hit = 1'b0;
            if (hit) begin
              for (int i = 0; i < CHECK_POS; i++) fb[8*i +: 8] = store[i];
              s = {2'b00, seq_ctr};
              seq_ctr = seq_ctr + 5'd1;
              if (fwd_en) begin
                fresh.push_back(frame_of(KIND_LAST, s, fb, CNT_LAST));
                fresh.push_back(frame_of(KIND_END, {2'b00, seq_ctr} | SEQ_END_FLAG,
                                         120'(END_PATTERN[47:24]), CNT_END_SHORT));
              end
              in_tx = 1'b0;
            end
          end
          fill = pos;
        end
        default: ;
      endcase
      if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) due_frames.push_back(fresh[i]);
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_frame(vfd_result_t got);
      vfd_result_t want;
      if (due_frames.size() == 0) begin
        report($sformatf("unexpected frame kind %0d seq %h", got.kind, got.seq));
        return;
      end
      want = due_frames.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.seq !== want.seq)
        report($sformatf("frame_seq got %h want %h", got.seq, want.seq));
      if (got.lo !== want.lo)
        report($sformatf("bytes_low got %h want %h", got.lo, want.lo));
      if (got.hi !== want.hi)
        report($sformatf("bytes_high got %h want %h", got.hi, want.hi));
      if (got.cnt !== want.cnt)
        report($sformatf("byte_count got %0d want %0d", got.cnt, want.cnt));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         cfg_wr_en   = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata    = 8'h00;
  logic [1:0]   in_tuser    = 2'd0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  frame_scoreboard sb = new(FPS);

  rx_style_t   rx_style  = RX_ALWAYS;
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_tick   = 0;

  bit          tx_gaps    = 1'b1;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  voice_frame_deframer_top #(
    .FRAMES_PER_SUPERFRAME(FPS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_MOSTLY: out_tready <= ($urandom_range(3) != 0);
        RX_HALF:   out_tready <= 1'($urandom_range(1));
        default:   out_tready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : watch_out
    vfd_result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind = kind_t'(out_tuser);
      seen.seq  = out_tdata[6:0];
      seen.lo   = out_tdata[70:7];
      seen.hi   = out_tdata[126:71];
      seen.cnt  = out_tdata[130:127];
      seen.last = out_tlast;
      sb.check_frame(seen);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
    int unsigned idle;
    if (tx_gaps && burst_left == 0) begin
      idle = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(mode, data);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // bias towards pattern bytes to provoke near matches
  task automatic send_bytes(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(11))
        0:       b = PAT_FILL;
        1:       b = PAT_SYNC;
        2:       b = PAT_TAIL;
        default: b = 8'($urandom_range(255));
      endcase
      send_item(MODE_DATA, b);
    end
  endtask

  // place the end pattern so that it lands on byte positions 9 to 14
  task automatic send_end_pattern(input bit broken);
    int unsigned lead;
    int unsigned bad;
    logic [47:0] pat;
    if (sb.fill <= 9) lead = 9 - sb.fill;
    else if (sb.fill <= 21) lead = 21 - sb.fill;
    else lead = 33 - sb.fill;
    send_bytes(lead);
    pat = END_PATTERN;
    if (broken) begin
      bad = $urandom_range(5);
      pat[8*bad +: 8] = pat[8*bad +: 8] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 6; i++) send_item(MODE_DATA, pat[8*i +: 8]);
  endtask

  task automatic send_transmission();
    int unsigned pick;
    int unsigned target;
    send_item(MODE_START, 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 8) begin
      target = $urandom_range(19, 20);
      while (sb.seq_ctr != target) send_bytes(1);
    end else if (pick < 55) send_bytes($urandom_range(0, 40));
    else if (pick < 88) send_bytes($urandom_range(41, 150));
    else send_bytes($urandom_range(230, 290));
    pick = $urandom_range(99);
    if (pick < 65) send_end_pattern(1'b0);
    else if (pick < 80) send_item(MODE_FORCE_END, 8'($urandom_range(255)));
    else if (pick < 90) send_end_pattern(1'b1);
  endtask

  task automatic send_noise();
    int unsigned n;
    logic [1:0]  m;
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(9))
        7:       m = MODE_FORCE_END;
        8:       m = MODE_UNUSED;
        9:       m = MODE_START;
        default: m = MODE_DATA;
      endcase
      send_item(m, 8'($urandom_range(255)));
    end
  endtask

  // hold off until every expected frame is out and the queue has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.due_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.fwd_en = v;
  endtask

  initial begin
    int unsigned base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    rx_style <= RX_MOSTLY;
    @(posedge clk);

    send_item(MODE_FORCE_END, 8'h00);
    send_item(MODE_UNUSED, 8'h5A);
    settle();
    write_enable(1'b1);
    send_item(MODE_START, 8'hFF);
    send_item(MODE_FORCE_END, 8'hFF);
    send_item(MODE_UNUSED, 8'hFF);
    for (int i = 0; i < 9; i++) send_item(MODE_DATA, LEAD_BYTES[8*i +: 8]);
    for (int i = 0; i < 6; i++) send_item(MODE_DATA, END_PATTERN[8*i +: 8]);
    send_item(MODE_FORCE_END, 8'h00);
    settle();

    base = items_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_enable(PHASE_EN[ph]);
      tx_gaps = PHASE_GAPS[ph];
      rx_style <= rx_style_t'(ph % 4);
      if (ph == 1) begin
        hold_req <= ~hold_req;
        send_item(MODE_START, 8'h00);
        send_bytes(120);
      end
      while (items_sent < base + (ph + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(99) < 70) send_transmission();
        else send_noise();
      end
      settle();
    end

    if (sb.errors == 0 && sb.due_frames.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
